/* rtl/core/flv_container_byte_parser_core_macros.svh */
// ----------------------------------------------------------------------------
// FLV byte parser assertion macros
// Shorthand for the clocked checks of the parser core. The macros expect
// signals named clock and reset in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef FLV_CONTAINER_BYTE_PARSER_CORE_MACROS_SVH
`define FLV_CONTAINER_BYTE_PARSER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCBP_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fcbp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FCBP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fcbp assertion failed");

`endif

/* rtl/core/fcbp_pkg.sv */
// ----------------------------------------------------------------------------
// FLV byte parser package
// Record and queue status layouts, record kinds, parse phases, byte constants and the tag type lookup.
// ----------------------------------------------------------------------------
package fcbp_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [2:0] KIND_HDR_OK   = 3'd0;
   localparam logic [2:0] KIND_AUDIO    = 3'd1;
   localparam logic [2:0] KIND_VIDEO    = 3'd2;
   localparam logic [2:0] KIND_SCRIPT   = 3'd3;
   localparam logic [2:0] KIND_BAD_SIG  = 3'd4;
   localparam logic [2:0] KIND_BAD_TYPE = 3'd5;

   localparam logic [7:0]  TAG_TYPE_AUDIO  = 8'h08;
   localparam logic [7:0]  TAG_TYPE_VIDEO  = 8'h09;
   localparam logic [7:0]  TAG_TYPE_SCRIPT = 8'h12;
   localparam logic [23:0] FLV_SIGNATURE   = {8'h46, 8'h4C, 8'h56};
   localparam logic [7:0]  FLAG_AUDIO      = 8'h04;
   localparam logic [7:0]  FLAG_VIDEO      = 8'h01;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PREV,
      PH_TAGHDR,
      PH_PAYLOAD
   } fcbp_phase_type;

   typedef struct packed {
      logic [2:0]  record_kind;
      logic [7:0]  version;
      logic        has_audio;
      logic        has_video;
      logic [31:0] header_length;
      logic [31:0] prev_tag_size;
      logic [23:0] data_size;
      logic [23:0] timestamp;
      logic [7:0]  timestamp_ext;
      logic [23:0] stream_id;
      logic [3:0]  info_high_nibble;
      logic [3:0]  info_low_nibble;
   } fcbp_record_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fcbp_qstat_type;

   function automatic logic [2:0] tag_kind(input logic [7:0] tag_type);
      logic [2:0] kind;
      case (tag_type)
         TAG_TYPE_AUDIO:  kind = KIND_AUDIO;
         TAG_TYPE_VIDEO:  kind = KIND_VIDEO;
         TAG_TYPE_SCRIPT: kind = KIND_SCRIPT;
         default:         kind = KIND_BAD_TYPE;
      endcase
      return kind;
   endfunction

endpackage

/* rtl/core/fcbp_parser.sv */
// ----------------------------------------------------------------------------
// FLV byte parser front end
// Takes one byte per beat, tracks the header and tag structure and hands a
// finished record to the record queue in the same cycle.
// ----------------------------------------------------------------------------
module fcbp_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               data_byte,
   input  logic                     start_of_file,
   output logic                     rec_push,
   output fcbp_pkg::fcbp_record_type rec
);
   import fcbp_pkg::*;

   fcbp_phase_type phase_ff, phase_in, phase_v;
   logic [23:0] cnt_ff, cnt_in, cnt_v, cnt_dec;
   logic [23:0] sig_ff, sig_in, sig_v;
   logic        halted_ff, halted_in, halted_v;
   logic [7:0]  version_ff, version_in;
   logic [7:0]  flags_ff, flags_in;
   logic [31:0] hlen_ff, hlen_in;
   logic [31:0] prev_ff, prev_in;
   logic [7:0]  ttype_ff, ttype_in;
   logic [23:0] dsize_ff, dsize_in;
   logic [23:0] ts_ff, ts_in;
   logic [7:0]  tsext_ff, tsext_in;
   logic [23:0] sid_ff, sid_in;
   logic [2:0]  kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         cnt_ff    <= '0;
         sig_ff    <= '0;
         halted_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         sig_ff    <= sig_in;
         halted_ff <= halted_in;
      end
      version_ff <= version_in;
      flags_ff   <= flags_in;
      hlen_ff    <= hlen_in;
      prev_ff    <= prev_in;
      ttype_ff   <= ttype_in;
      dsize_ff   <= dsize_in;
      ts_ff      <= ts_in;
      tsext_ff   <= tsext_in;
      sid_ff     <= sid_in;
   end

   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      sig_in     = sig_ff;
      halted_in  = halted_ff;
      version_in = version_ff;
      flags_in   = flags_ff;
      hlen_in    = hlen_ff;
      prev_in    = prev_ff;
      ttype_in   = ttype_ff;
      dsize_in   = dsize_ff;
      ts_in      = ts_ff;
      tsext_in   = tsext_ff;
      sid_in     = sid_ff;
      phase_v    = phase_ff;
      cnt_v      = cnt_ff;
      sig_v      = sig_ff;
      halted_v   = halted_ff;
      cnt_dec    = cnt_ff;
      kind       = tag_kind(ttype_ff);
      rec_push   = 1'b0;
      rec        = '0;
      if (accept) begin
         // A start mark restarts the parse on this very byte.
         if (start_of_file) begin
            phase_v  = PH_HEADER;
            cnt_v    = '0;
            sig_v    = '0;
            halted_v = 1'b0;
         end
         phase_in  = phase_v;
         cnt_in    = cnt_v;
         sig_in    = sig_v;
         halted_in = halted_v;
         if (!halted_v) begin
            case (phase_v)
               PH_HEADER: begin
                  if (cnt_v < 24'd3) begin
                     sig_in = {sig_v[15:0], data_byte};
                  end else if (cnt_v == 24'd3) begin
                     version_in = data_byte;
                  end else if (cnt_v == 24'd4) begin
                     flags_in = data_byte;
                  end else begin
                     hlen_in = {hlen_ff[23:0], data_byte};
                  end
                  cnt_in = cnt_v + 24'd1;
                  if (cnt_v == 24'd8) begin
                     rec_push           = 1'b1;
                     rec.record_kind    = (sig_v == FLV_SIGNATURE) ? KIND_HDR_OK : KIND_BAD_SIG;
                     rec.version        = version_ff;
                     rec.has_audio      = |(flags_ff & FLAG_AUDIO);
                     rec.has_video      = |(flags_ff & FLAG_VIDEO);
                     rec.header_length  = hlen_in;
                     cnt_in             = '0;
                     if (sig_v == FLV_SIGNATURE) begin
                        phase_in = PH_PREV;
                     end else begin
                        halted_in = 1'b1;
                     end
                  end
               end
               PH_PREV: begin
                  prev_in = {prev_ff[23:0], data_byte};
                  if (cnt_v == 24'd3) begin
                     cnt_in   = '0;
                     phase_in = PH_TAGHDR;
                  end else begin
                     cnt_in = cnt_v + 24'd1;
                  end
               end
               PH_TAGHDR: begin
                  if (cnt_v == 24'd0) begin
                     ttype_in = data_byte;
                  end else if (cnt_v < 24'd4) begin
                     dsize_in = {dsize_ff[15:0], data_byte};
                  end else if (cnt_v < 24'd7) begin
                     ts_in = {ts_ff[15:0], data_byte};
                  end else if (cnt_v == 24'd7) begin
                     tsext_in = data_byte;
                  end else begin
                     sid_in = {sid_ff[15:0], data_byte};
                  end
                  cnt_in = cnt_v + 24'd1;
                  if (cnt_v == 24'd10) begin
                     rec.prev_tag_size = prev_ff;
                     rec.data_size     = dsize_ff;
                     rec.timestamp     = ts_ff;
                     rec.timestamp_ext = tsext_ff;
                     rec.stream_id     = sid_in;
                     rec.record_kind   = kind;
                     if (kind == KIND_BAD_TYPE) begin
                        rec_push  = 1'b1;
                        halted_in = 1'b1;
                        cnt_in    = '0;
                     end else if (dsize_ff == 24'd0) begin
                        rec_push = 1'b1;
                        cnt_in   = '0;
                        phase_in = PH_PREV;
                     end else begin
                        cnt_in   = dsize_ff;
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end
               PH_PAYLOAD: begin
                  // The counter holds the bytes left; it equals the size only
                  // on the first payload byte.
                  if (cnt_v == dsize_ff) begin
                     rec_push          = 1'b1;
                     rec.record_kind   = kind;
                     rec.prev_tag_size = prev_ff;
                     rec.data_size     = dsize_ff;
                     rec.timestamp     = ts_ff;
                     rec.timestamp_ext = tsext_ff;
                     rec.stream_id     = sid_ff;
                     if (kind != KIND_SCRIPT) begin
                        rec.info_high_nibble = data_byte[7:4];
                        rec.info_low_nibble  = data_byte[3:0];
                     end
                  end
                  cnt_dec = (cnt_v != 24'd0) ? (cnt_v - 24'd1) : cnt_v;
                  cnt_in  = cnt_dec;
                  if (cnt_dec == 24'd0) begin
                     phase_in = PH_PREV;
                  end
               end
               default: begin
                  phase_in = PH_HEADER;
               end
            endcase
         end
      end
   end

endmodule

/* rtl/core/fcbp_rec_queue.sv */
// ----------------------------------------------------------------------------
// FLV byte parser record queue
// Short queue of finished records; the oldest one drives the result ports.
// ----------------------------------------------------------------------------
module fcbp_rec_queue #(
   parameter int DEPTH = fcbp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  fcbp_pkg::fcbp_record_type push_rec,
   input  logic                      pop,
   output fcbp_pkg::fcbp_record_type head_rec,
   output fcbp_pkg::fcbp_qstat_type  qstat
);
   import fcbp_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   fcbp_record_type entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign qstat.full  = (count_ff == CW'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head_rec    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

/* rtl/core/flv_container_byte_parser_core.sv */
// ----------------------------------------------------------------------------
// FLV container byte parser core
// Channel   | handshake            | beat
// ----------+----------------------+---------------------------------------
// request   | push / full          | one file byte and its start-of-file mark
// response  | pop / empty          | one header or tag record
//
// One byte is taken every cycle while full is low. A record is written into
// the record queue at the edge its closing byte is taken and is visible on
// the rsp_ ports from then on while it is the oldest record. full rises
// only when the record queue holds QUEUE_DEPTH records. Reset is synchronous
// and empties the queue and restarts parsing at byte 0 of a file header.
// ----------------------------------------------------------------------------
`include "flv_container_byte_parser_core_macros.svh"

module flv_container_byte_parser_core #(
   parameter int QUEUE_DEPTH = fcbp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_file,
   input  logic        pop,
   output logic        empty,
   output logic [2:0]  rsp_record_kind,
   output logic [7:0]  rsp_version,
   output logic        rsp_has_audio,
   output logic        rsp_has_video,
   output logic [31:0] rsp_header_length,
   output logic [31:0] rsp_prev_tag_size,
   output logic [23:0] rsp_data_size,
   output logic [23:0] rsp_timestamp,
   output logic [7:0]  rsp_timestamp_ext,
   output logic [23:0] rsp_stream_id,
   output logic [3:0]  rsp_info_high_nibble,
   output logic [3:0]  rsp_info_low_nibble
);
   import fcbp_pkg::*;

   logic            accept;
   logic            rec_push;
   fcbp_record_type rec;
   fcbp_record_type head_rec;
   fcbp_qstat_type  qstat;

   assign accept = push && !qstat.full;
   assign full   = qstat.full;
   assign empty  = qstat.empty;

   fcbp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .start_of_file (req_start_of_file),
      .rec_push      (rec_push),
      .rec           (rec)
   );

   fcbp_rec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_rec_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rec_push),
      .push_rec (rec),
      .pop      (pop),
      .head_rec (head_rec),
      .qstat    (qstat)
   );

   assign rsp_record_kind      = head_rec.record_kind;
   assign rsp_version          = head_rec.version;
   assign rsp_has_audio        = head_rec.has_audio;
   assign rsp_has_video        = head_rec.has_video;
   assign rsp_header_length    = head_rec.header_length;
   assign rsp_prev_tag_size    = head_rec.prev_tag_size;
   assign rsp_data_size        = head_rec.data_size;
   assign rsp_timestamp        = head_rec.timestamp;
   assign rsp_timestamp_ext    = head_rec.timestamp_ext;
   assign rsp_stream_id        = head_rec.stream_id;
   assign rsp_info_high_nibble = head_rec.info_high_nibble;
   assign rsp_info_low_nibble  = head_rec.info_low_nibble;

   // Records only enter the queue on an accepted byte.
   `FCBP_ASSERT_SAME(a_push_on_accept, rec_push, accept)
   `FCBP_ASSERT_SAME(a_kind_legal, !qstat.empty, rsp_record_kind <= KIND_BAD_TYPE)
   `FCBP_ASSERT_NEXT(a_push_lands, rec_push && qstat.empty, !qstat.empty)
   `FCBP_ASSERT_NEXT(a_no_phantom, qstat.empty && !rec_push, qstat.empty)

endmodule

/* dv/flv_container_byte_parser_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FLV container byte parser core testbench
// Streams FLV files into the parser one byte beat at a time: a short directed
// opening with extreme field values, a start mark mid-payload and a halted
// parser, then random files that are mostly well formed, mixed with bad
// signatures, bad tag types, cut-off payloads and stray bytes. A scoreboard
// class parses the same bytes and checks every record field by field.
// ----------------------------------------------------------------------------

module flv_container_byte_parser_core_tb;
   import fcbp_pkg::*;

   localparam int RANDOM_BYTES     = 850;
   localparam int HEADER_BYTES     = 9;
   localparam int PREV_SIZE_BYTES  = 4;
   localparam int TAG_HEADER_BYTES = 11;
   localparam int DRAIN_LIMIT      = 20000;
   localparam int SETTLE_CYCLES    = 8;
   localparam int MAX_PRINTED      = 100;

   class flv_record_board;
      fcbp_record_type expected_records[$];
      int errors = 0;
      int checked = 0;
      int parsed_bytes = 0;

      fcbp_phase_type phase = PH_HEADER;
      logic [23:0] count = '0;
      logic [23:0] sig_shift = '0;
      logic        halted = 1'b0;
      logic [7:0]  version = '0;
      logic [7:0]  flags = '0;
      logic [31:0] hdr_len = '0;
      logic [31:0] prev_size = '0;
      logic [7:0]  tag_type = '0;
      logic [23:0] tag_size = '0;
      logic [23:0] stamp = '0;
      logic [7:0]  stamp_ext = '0;
      logic [23:0] stream = '0;

      function logic [2:0] kind_for_type(logic [7:0] t);
         if (t == TAG_TYPE_AUDIO) return KIND_AUDIO;
         if (t == TAG_TYPE_VIDEO) return KIND_VIDEO;
         if (t == TAG_TYPE_SCRIPT) return KIND_SCRIPT;
         return KIND_BAD_TYPE;
      endfunction

      function void add_tag_record(logic [2:0] kind, logic [7:0] info);
         fcbp_record_type rec;
         rec = '0;
         rec.record_kind      = kind;
         rec.prev_tag_size    = prev_size;
         rec.data_size        = tag_size;
         rec.timestamp        = stamp;
         rec.timestamp_ext    = stamp_ext;
         rec.stream_id        = stream;
         rec.info_high_nibble = info[7:4];
         rec.info_low_nibble  = info[3:0];
         expected_records.push_back(rec);
      endfunction

      // Advances the parse by one accepted byte and queues the record it closes.
      function void note_byte(logic [7:0] b, logic mark);
         fcbp_record_type rec;
         logic [2:0] kind;
         if (mark) begin
            phase = PH_HEADER;
            count = '0;
            sig_shift = '0;
            halted = 1'b0;
         end
         if (halted) return;
         parsed_bytes++;
         case (phase)
            PH_HEADER: begin
               if (count < 3) sig_shift = {sig_shift[15:0], b};
               else if (count == 3) version = b;
               else if (count == 4) flags = b;
               else hdr_len = {hdr_len[23:0], b};
               count++;
               if (count == HEADER_BYTES) begin
                  rec = '0;
                  rec.record_kind   = (sig_shift == FLV_SIGNATURE) ? KIND_HDR_OK : KIND_BAD_SIG;
                  rec.version       = version;
                  rec.has_audio     = (flags & FLAG_AUDIO) != 0;
                  rec.has_video     = (flags & FLAG_VIDEO) != 0;
                  rec.header_length = hdr_len;
                  expected_records.push_back(rec);
                  count = '0;
                  if (rec.record_kind == KIND_BAD_SIG) halted = 1'b1;
                  else phase = PH_PREV;
               end
            end
            PH_PREV: begin
               prev_size = {prev_size[23:0], b};
               count++;
               if (count == PREV_SIZE_BYTES) begin
                  count = '0;
                  phase = PH_TAGHDR;
               end
            end
            PH_TAGHDR: begin
               if (count == 0) tag_type = b;
               else if (count < 4) tag_size = {tag_size[15:0], b};
               else if (count < 7) stamp = {stamp[15:0], b};
               else if (count == 7) stamp_ext = b;
               else stream = {stream[15:0], b};
               count++;
               if (count == TAG_HEADER_BYTES) begin
                  kind = kind_for_type(tag_type);
                  if (kind == KIND_BAD_TYPE) begin
                     add_tag_record(kind, 8'h00);
                     halted = 1'b1;
                     count = '0;
                  end else if (tag_size == 0) begin
                     add_tag_record(kind, 8'h00);
                     count = '0;
                     phase = PH_PREV;
                  end else begin
                     count = tag_size;
                     phase = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               // Only the first payload byte closes a record; the rest are counted off.
               if (count == tag_size) begin
                  kind = kind_for_type(tag_type);
                  add_tag_record(kind, (kind == KIND_SCRIPT) ? 8'h00 : b);
               end
               if (count != 0) count--;
               if (count == 0) phase = PH_PREV;
            end
         endcase
      endfunction

      task report_mismatch(string msg);
         if (errors < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("record %0d %s: got 0x%0h, expected 0x%0h",
                                      checked, name, got, want));
      endtask

      task check_record(fcbp_record_type got);
         fcbp_record_type want;
         if (expected_records.size() == 0) begin
            report_mismatch($sformatf("record of kind %0d arrived with none expected",
                                      got.record_kind));
            return;
         end
         want = expected_records.pop_front();
         checked++;
         check_field("record_kind", 32'(got.record_kind), 32'(want.record_kind));
         check_field("version", 32'(got.version), 32'(want.version));
         check_field("has_audio", 32'(got.has_audio), 32'(want.has_audio));
         check_field("has_video", 32'(got.has_video), 32'(want.has_video));
         check_field("header_length", got.header_length, want.header_length);
         check_field("prev_tag_size", got.prev_tag_size, want.prev_tag_size);
         check_field("data_size", 32'(got.data_size), 32'(want.data_size));
         check_field("timestamp", 32'(got.timestamp), 32'(want.timestamp));
         check_field("timestamp_ext", 32'(got.timestamp_ext), 32'(want.timestamp_ext));
         check_field("stream_id", 32'(got.stream_id), 32'(want.stream_id));
         check_field("info_high_nibble", 32'(got.info_high_nibble),
                     32'(want.info_high_nibble));
         check_field("info_low_nibble", 32'(got.info_low_nibble),
                     32'(want.info_low_nibble));
      endtask
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_data_byte = '0;
   logic        req_start_of_file = 1'b0;
   logic        pop = 1'b0;
   logic        empty;
   logic [2:0]  rsp_record_kind;
   logic [7:0]  rsp_version;
   logic        rsp_has_audio;
   logic        rsp_has_video;
   logic [31:0] rsp_header_length;
   logic [31:0] rsp_prev_tag_size;
   logic [23:0] rsp_data_size;
   logic [23:0] rsp_timestamp;
   logic [7:0]  rsp_timestamp_ext;
   logic [23:0] rsp_stream_id;
   logic [3:0]  rsp_info_high_nibble;
   logic [3:0]  rsp_info_low_nibble;

   int send_idle_pct = 31;
   int recv_idle_pct = 67;

   flv_record_board flv_records = new;

   flv_container_byte_parser_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_data_byte        (req_data_byte),
      .req_start_of_file    (req_start_of_file),
      .pop                  (pop),
      .empty                (empty),
      .rsp_record_kind      (rsp_record_kind),
      .rsp_version          (rsp_version),
      .rsp_has_audio        (rsp_has_audio),
      .rsp_has_video        (rsp_has_video),
      .rsp_header_length    (rsp_header_length),
      .rsp_prev_tag_size    (rsp_prev_tag_size),
      .rsp_data_size        (rsp_data_size),
      .rsp_timestamp        (rsp_timestamp),
      .rsp_timestamp_ext    (rsp_timestamp_ext),
      .rsp_stream_id        (rsp_stream_id),
      .rsp_info_high_nibble (rsp_info_high_nibble),
      .rsp_info_low_nibble  (rsp_info_low_nibble)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // An input beat is noted before a record beat of the same edge is checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) flv_records.note_byte(req_data_byte, req_start_of_file);
         if (pop && !empty)
            flv_records.check_record({rsp_record_kind, rsp_version, rsp_has_audio,
                                      rsp_has_video, rsp_header_length, rsp_prev_tag_size,
                                      rsp_data_size, rsp_timestamp, rsp_timestamp_ext,
                                      rsp_stream_id, rsp_info_high_nibble,
                                      rsp_info_low_nibble});
      end
   end

   // Push stays high on return so that beats can follow back to back.
   task automatic send_byte(input logic [7:0] value, input logic mark);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data_byte <= value;
      req_start_of_file <= mark;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic send_word(input logic [31:0] word);
      send_byte(word[31:24], 1'b0);
      send_byte(word[23:16], 1'b0);
      send_byte(word[15:8], 1'b0);
      send_byte(word[7:0], 1'b0);
   endtask

   // One file with random content. lost is set when the parser is left halted
   // or mid-payload, so that the next file must carry a start mark.
   task automatic send_file(input logic mark, output bit lost);
      logic [23:0] sig;
      logic [31:0] word;
      logic [7:0]  tag_type;
      logic [23:0] tag_size;
      int          n_tags;
      int          n_payload;
      int          pick;
      lost = 1'b0;
      word = $urandom;
      if ($urandom_range(99) < 10) sig = word[23:0];
      else sig = FLV_SIGNATURE;
      send_byte(sig[23:16], mark);
      send_byte(sig[15:8], 1'b0);
      send_byte(sig[7:0], 1'b0);
      word = $urandom;
      send_byte(word[7:0], 1'b0);
      send_byte(word[15:8], 1'b0);
      send_word($urandom);
      if (sig != FLV_SIGNATURE) begin
         lost = 1'b1;
         return;
      end
      n_tags = $urandom_range(1, 5);
      repeat (n_tags) begin
         send_word($urandom);
         word = $urandom;
         pick = $urandom_range(99);
         if (pick < 30) tag_type = TAG_TYPE_AUDIO;
         else if (pick < 60) tag_type = TAG_TYPE_VIDEO;
         else if (pick < 88) tag_type = TAG_TYPE_SCRIPT;
         else tag_type = word[7:0];
         pick = $urandom_range(99);
         if (pick < 20) tag_size = '0;
         else if (pick < 93) tag_size = 24'($urandom_range(1, 6));
         else tag_size = word[31:8];
         send_byte(tag_type, 1'b0);
         send_byte(tag_size[23:16], 1'b0);
         send_byte(tag_size[15:8], 1'b0);
         send_byte(tag_size[7:0], 1'b0);
         word = $urandom;
         send_byte(word[23:16], 1'b0);
         send_byte(word[15:8], 1'b0);
         send_byte(word[7:0], 1'b0);
         send_byte(word[31:24], 1'b0);
         word = $urandom;
         send_byte(word[23:16], 1'b0);
         send_byte(word[15:8], 1'b0);
         send_byte(word[7:0], 1'b0);
         if (flv_records.kind_for_type(tag_type) == KIND_BAD_TYPE) begin
            lost = 1'b1;
            return;
         end
         // Payloads longer than eight bytes are cut short after one to three bytes by the next start mark.
         n_payload = (tag_size > 8) ? $urandom_range(1, 3) : tag_size;
         repeat (n_payload) begin
            word = $urandom;
            send_byte(word[7:0], 1'b0);
         end
         if (tag_size > 8) begin
            lost = 1'b1;
            return;
         end
      end
   endtask

   initial begin
      bit          lost;
      int          target;
      int          wait_cycles;
      int          n;
      logic [31:0] word;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Clean header with every field at its maximum and no start mark after
      // reset, then a video tag of the largest size closed by its first byte.
      send_byte(FLV_SIGNATURE[23:16], 1'b0);
      send_byte(FLV_SIGNATURE[15:8], 1'b0);
      send_byte(FLV_SIGNATURE[7:0], 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_word(32'hFFFF_FFFF);
      send_word(32'hFFFF_FFFF);
      send_byte(TAG_TYPE_VIDEO, 1'b0);
      repeat (10) send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      // A start mark inside that payload opens a file whose signature breaks
      // off after two bytes; the parser halts and ignores the byte after it.
      send_byte(FLV_SIGNATURE[23:16], 1'b1);
      send_byte(FLV_SIGNATURE[15:8], 1'b0);
      repeat (7) send_byte(8'h00, 1'b0);
      send_byte(FLV_SIGNATURE[23:16], 1'b0);

      lost = 1'b1;
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 31;
               recv_idle_pct = 67;
            end
            1: begin
               send_idle_pct = 67;
               recv_idle_pct = 31;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         target = flv_records.parsed_bytes + RANDOM_BYTES / 3;
         while (flv_records.parsed_bytes < target) begin
            send_file(lost || ($urandom_range(99) < 85), lost);
            if ($urandom_range(99) < 20) begin
               n = $urandom_range(1, 4);
               repeat (n) begin
                  word = $urandom;
                  send_byte(word[7:0], word[31:28] < 3);
               end
               lost = 1'b1;
            end
         end
      end
      push <= 1'b0;

      repeat (2) @(posedge clock);
      wait_cycles = 0;
      while (flv_records.expected_records.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (flv_records.expected_records.size() != 0)
         flv_records.report_mismatch($sformatf("%0d expected records never arrived",
                                               flv_records.expected_records.size()));
      if (flv_records.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
